@@ design/vtg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtg_pkg: shared types and constants of the vector tile geometry decoder
// Transaction payloads, command ids, result kinds, fault codes and helpers.
// ----------------------------------------------------------------------------
package vtg_pkg;

  localparam int RES_MAX = 3;

  localparam logic [2:0] CMD_MOVETO = 3'd1;
  localparam logic [2:0] CMD_LINETO = 3'd2;
  localparam logic [2:0] CMD_CLOSE  = 3'd7;

  localparam logic [1:0] KIND_VERTEX = 2'd0;
  localparam logic [1:0] KIND_DONE   = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] FAULT_NONE      = 3'd0;
  localparam logic [2:0] FAULT_BAD_ID    = 3'd1;
  localparam logic [2:0] FAULT_BAD_MOVE  = 3'd2;
  localparam logic [2:0] FAULT_LINE_1ST  = 3'd3;
  localparam logic [2:0] FAULT_BAD_CLOSE = 3'd4;
  localparam logic [2:0] FAULT_TRUNC     = 3'd5;
  localparam logic [2:0] FAULT_UNCLOSED  = 3'd6;
  localparam logic [2:0] FAULT_TOO_FEW   = 3'd7;

  typedef struct packed {
    logic [31:0] word;
    logic        stream_end;
  } vtg_in_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        vertex_total;
    logic [2:0]         fault;
    logic               final_res;
  } vtg_out_t;

  // results caused by one input transaction
  typedef struct packed {
    logic [1:0]                 count;
    vtg_out_t [RES_MAX-1:0]     item;
  } vtg_batch_t;

  function automatic logic [31:0] unzigzag(input logic [31:0] v);
    unzigzag = {1'b0, v[31:1]} ^ {32{v[0]}};
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

@@ design/vector_tile_geometry_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_tile_geometry_decoder: streaming vector tile geometry decoder
// Decodes command and zigzag parameter words into vertices and a per-feature
// done or error result.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one geometry word per
//   transaction; stream_end marks the last word of a feature.
//   Output channel (out_valid/out_ready/out_data) returns vertex, done and
//   error results in stream order.
//   cfg_we/cfg_wdata write polygon_mode; write it only while the block is idle.
// Output: a word's first result is registered and presented in the cycle after its transaction.
// Throughput: one word per cycle while out_ready is high and each word causes at most one result.
//   A feature-ending word can cause up to three results; these leave the
//   result register one per cycle while out_ready is high, and the next word is taken in the cycle
//   the last of them is taken.
// Reset: rst clears polygon_mode to point mode and all feature state; no
//   results are pending afterwards.
// Stall: while out_ready is low, the result register holds and in_ready stays
//   low as long as any result is waiting.
// ----------------------------------------------------------------------------
module vector_tile_geometry_decoder (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  vtg_pkg::vtg_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output vtg_pkg::vtg_out_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_wdata
);
  import vtg_pkg::*;

  vtg_batch_t batch;
  logic       in_fire;
  logic       can_load;

  assign in_ready = can_load;
  assign in_fire  = in_valid && in_ready;

  vtg_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_fire   (in_fire),
    .in_data   (in_data),
    .batch     (batch)
  );

  vtg_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (in_fire),
    .batch     (batch),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  // a transaction that causes results shows one in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (in_fire && batch.count != 2'd0) |=> out_valid)
    else $error("results of accepted word not presented");

  // a transaction that causes no result leaves the output empty
  a_no_result: assert property (@(posedge clk) disable iff (rst)
    (in_fire && batch.count == 2'd0) |=> !out_valid)
    else $error("result presented for a word that caused none");

  // vertices never end a feature; done and error always do
  a_kind_final: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.kind == KIND_VERTEX) == !out_data.final_res))
    else $error("result kind and final flag disagree");

  // only error results carry a fault, and final results carry no position
  a_fault_pos: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.final_res) |->
      (out_data.pos_x == 32'sd0 && out_data.pos_y == 32'sd0 &&
       ((out_data.kind == KIND_ERROR) == (out_data.fault != FAULT_NONE))))
    else $error("final result carries position or inconsistent fault");
`endif

endmodule

@@ design/vtg_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtg_decode: geometry word decoder and feature state
// Updates the running position and ring state for one word and forms the
// vertex, closing vertex and done/error results that the word causes.
// ----------------------------------------------------------------------------
module vtg_decode (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               in_fire,
  input  vtg_pkg::vtg_in_t   in_data,
  output vtg_pkg::vtg_batch_t batch
);
  import vtg_pkg::*;

  logic        polygon_mode;
  logic [31:0] cur_x, cur_y, start_x, start_y, vertex_count;
  logic [28:0] pairs_left;
  logic        want_y, ring_open, ring_closed, failed;

  logic [31:0] cur_x_next, cur_y_next, start_x_next, start_y_next, vertex_count_next;
  logic [28:0] pairs_left_next;
  logic        want_y_next, ring_open_next, ring_closed_next, failed_next;

  logic [2:0]  cmd_id;
  logic [28:0] cmd_count;
  logic [2:0]  fault;
  logic [1:0]  n;
  logic [31:0] delta;
  logic        cmd_err;

  assign cmd_id    = in_data.word[2:0];
  assign cmd_count = in_data.word[31:3];
  assign delta     = unzigzag(in_data.word);

  always_comb begin
    cur_x_next        = cur_x;
    cur_y_next        = cur_y;
    start_x_next      = start_x;
    start_y_next      = start_y;
    vertex_count_next = vertex_count;
    pairs_left_next   = pairs_left;
    want_y_next       = want_y;
    ring_open_next    = ring_open;
    ring_closed_next  = ring_closed;
    failed_next       = failed;
    fault             = FAULT_NONE;
    cmd_err           = 1'b0;
    n                 = 2'd0;
    batch             = '0;

    if (failed) begin
      // drop words until the feature ends
    end else if (pairs_left == '0 && !want_y) begin
      if (!polygon_mode) begin
        if (cmd_id != CMD_MOVETO) fault = FAULT_BAD_ID;
        else pairs_left_next = cmd_count;
      end else begin
        case (cmd_id)
          CMD_MOVETO: begin
            if (cmd_count != 29'd1 || ring_open) fault = FAULT_BAD_MOVE;
            else pairs_left_next = 29'd1;
          end
          CMD_LINETO: begin
            if (!ring_open) fault = FAULT_LINE_1ST;
            else pairs_left_next = cmd_count;
          end
          CMD_CLOSE: begin
            if (cmd_count != 29'd1) fault = FAULT_BAD_CLOSE;
            else ring_closed_next = 1'b1;
          end
          default: fault = FAULT_BAD_ID;
        endcase
      end
      if (fault != FAULT_NONE) begin
        cmd_err = 1'b1;
        batch.item[0].kind         = KIND_ERROR;
        batch.item[0].vertex_total = vertex_count;
        batch.item[0].fault        = fault;
        batch.item[0].final_res    = 1'b1;
        n = 2'd1;
        failed_next = 1'b1;
      end
    end else if (!want_y) begin
      cur_x_next  = cur_x + delta;
      want_y_next = 1'b1;
    end else begin
      cur_y_next      = cur_y + delta;
      want_y_next     = 1'b0;
      pairs_left_next = pairs_left - 29'd1;
      batch.item[0].kind  = KIND_VERTEX;
      batch.item[0].pos_x = cur_x;
      batch.item[0].pos_y = cur_y_next;
      n = 2'd1;
      vertex_count_next = sat_inc(vertex_count);
      if (polygon_mode && !ring_open) begin
        start_x_next   = cur_x;
        start_y_next   = cur_y_next;
        ring_open_next = 1'b1;
      end
    end

    // feature end: emit closing vertex if needed, then done or error
    if (!failed && !cmd_err && in_data.stream_end) begin
      if (pairs_left_next != '0 || want_y_next) begin
        fault = FAULT_TRUNC;
      end else if (!polygon_mode) begin
        fault = FAULT_NONE;
      end else if (!ring_closed_next) begin
        fault = FAULT_UNCLOSED;
      end else begin
        if (ring_open_next && (cur_x_next != start_x_next || cur_y_next != start_y_next)) begin
          batch.item[n].kind  = KIND_VERTEX;
          batch.item[n].pos_x = start_x_next;
          batch.item[n].pos_y = start_y_next;
          n = n + 2'd1;
          vertex_count_next = sat_inc(vertex_count_next);
        end
        fault = (vertex_count_next < 32'd4) ? FAULT_TOO_FEW : FAULT_NONE;
      end
      batch.item[n].kind         = (fault != FAULT_NONE) ? KIND_ERROR : KIND_DONE;
      batch.item[n].vertex_total = vertex_count_next;
      batch.item[n].fault        = fault;
      batch.item[n].final_res    = 1'b1;
      n = n + 2'd1;
    end

    // the last word of a feature clears all feature state
    if (in_data.stream_end) begin
      cur_x_next        = '0;
      cur_y_next        = '0;
      start_x_next      = '0;
      start_y_next      = '0;
      vertex_count_next = '0;
      pairs_left_next   = '0;
      want_y_next       = 1'b0;
      ring_open_next    = 1'b0;
      ring_closed_next  = 1'b0;
      failed_next       = 1'b0;
    end

    batch.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      polygon_mode <= 1'b0;
      cur_x        <= '0;
      cur_y        <= '0;
      start_x      <= '0;
      start_y      <= '0;
      vertex_count <= '0;
      pairs_left   <= '0;
      want_y       <= 1'b0;
      ring_open    <= 1'b0;
      ring_closed  <= 1'b0;
      failed       <= 1'b0;
    end else begin
      if (cfg_we) polygon_mode <= cfg_wdata;
      if (in_fire) begin
        cur_x        <= cur_x_next;
        cur_y        <= cur_y_next;
        start_x      <= start_x_next;
        start_y      <= start_y_next;
        vertex_count <= vertex_count_next;
        pairs_left   <= pairs_left_next;
        want_y       <= want_y_next;
        ring_open    <= ring_open_next;
        ring_closed  <= ring_closed_next;
        failed       <= failed_next;
      end
    end
  end

endmodule

@@ design/vtg_out_buf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtg_out_buf: result register
// Holds the results of one decoded word and hands them out one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module vtg_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  vtg_pkg::vtg_batch_t batch,
  output logic                can_load,
  output logic                out_valid,
  input  logic                out_ready,
  output vtg_pkg::vtg_out_t   out_data
);
  import vtg_pkg::*;

  vtg_out_t [RES_MAX-1:0] slot;
  logic [1:0]             count;
  logic [1:0]             head;
  logic                   pop;

  assign out_valid = (count != 2'd0);
  assign out_data  = slot[head];
  assign pop       = out_valid && out_ready;
  // take a new batch when empty or once the last pending result leaves this cycle
  assign can_load  = (count == 2'd0) || (count == 2'd1 && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      head  <= 2'd0;
    end else if (load) begin
      count <= batch.count;
      head  <= 2'd0;
    end else if (pop) begin
      count <= count - 2'd1;
      head  <= head + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) slot <= batch.item;
  end

endmodule
